// ===== rtl/pctd_pkg.sv =====
// Package with field widths, command codes and sequencer states of the prefix-code decoder.
package pctd_pkg;

  localparam int CMD_W    = 2;
  localparam int ELEM_W   = 2;
  localparam int BYTE_W   = 8;
  localparam int LEN_IN_W = 16;
  localparam int SYM_W    = 8;
  localparam int SYMCNT_W = 9;
  localparam int BITIDX_W = 3;

  localparam logic [CMD_W-1:0] CMD_START = 2'd0;
  localparam logic [CMD_W-1:0] CMD_CODE  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DATA  = 2'd2;

  localparam logic [ELEM_W-1:0] ELEM_ZERO = 2'd0;
  localparam logic [ELEM_W-1:0] ELEM_ONE  = 2'd1;
  localparam logic [ELEM_W-1:0] ELEM_END  = 2'd2;

  localparam logic [BITIDX_W-1:0] BYTE_MSB = 3'd7;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_B_EVAL,
    ST_B_ZERO,
    ST_D_LOAD,
    ST_D_STEP,
    ST_D_CHECK,
    ST_FLUSH
  } state_e;

endpackage

// ===== rtl/pctd_stream_if.sv =====
// Valid/ready stream interfaces for the decoder's input and result channels.
interface pctd_in_if import pctd_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [CMD_W-1:0]    cmd;
  logic [ELEM_W-1:0]   code_element;
  logic [BYTE_W-1:0]   data_byte;
  logic [LEN_IN_W-1:0] block_length;

  modport source (output valid, cmd, code_element, data_byte, block_length, input ready);
  modport sink (input valid, cmd, code_element, data_byte, block_length, output ready);
endinterface

interface pctd_out_if import pctd_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SYM_W-1:0] symbol;
  logic             bad_code;
  logic             block_done;
  logic             last;

  modport source (output valid, symbol, bad_code, block_done, last, input ready);
  modport sink (input valid, symbol, bad_code, block_done, last, output ready);
endinterface

// ===== rtl/prefix_code_tree_decoder_core.sv =====
// Top level of the prefix-code tree decoder: sequencer, node memory and result registers.
// Start beats complete in the idle state; code-element beats pass through an evaluate state
// and, when a node is added, a clearing state. A data beat loads the cursor node, steps the
// tree for each decoded bit and hands off the last result, paced by the single registered
// read port of the node memory.
// Reset clears all control state; the node memory is not cleared but is tracked by the node
// count, and the root node's children live in flip-flops that reset and start clear at once.
module prefix_code_tree_decoder_core import pctd_pkg::*; #(
  parameter int MAX_NODES   = 512,
  parameter int LENGTH_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  pctd_in_if.sink     in_i,
  pctd_out_if.source  out_o
);

  localparam int IDX_W   = $clog2(MAX_NODES);
  localparam int CNT_W   = $clog2(MAX_NODES + 1);
  localparam int ENTRY_W = 2 * IDX_W + SYM_W;

  state_e                 state_q, state_d;
  logic [CNT_W-1:0]       node_count_q, node_count_d;
  logic [IDX_W-1:0]       build_cur_q, build_cur_d;
  logic [IDX_W-1:0]       decode_cur_q, decode_cur_d;
  logic [SYMCNT_W-1:0]    sym_cnt_q, sym_cnt_d;
  logic [LENGTH_BITS-1:0] left_q, left_d;
  logic [IDX_W-1:0]       root_kid0_q, root_kid0_d;
  logic [IDX_W-1:0]       root_kid1_q, root_kid1_d;
  logic                   pend_valid_q, pend_valid_d;
  logic                   out_valid_q, out_valid_d;

  logic [ELEM_W-1:0]      elem_q, elem_d;
  logic [BYTE_W-1:0]      byte_q, byte_d;
  logic [BITIDX_W-1:0]    bit_idx_q, bit_idx_d;
  logic [IDX_W-1:0]       cur_kid0_q, cur_kid0_d;
  logic [IDX_W-1:0]       cur_kid1_q, cur_kid1_d;
  logic [IDX_W-1:0]       nxt_q, nxt_d;
  logic [SYM_W-1:0]       pend_sym_q, pend_sym_d;
  logic                   pend_bad_q, pend_bad_d;
  logic                   pend_done_q, pend_done_d;
  logic [SYM_W-1:0]       out_sym_q, out_sym_d;
  logic                   out_bad_q, out_bad_d;
  logic                   out_done_q, out_done_d;
  logic                   out_last_q, out_last_d;

  logic                   wr_en;
  logic [IDX_W-1:0]       wr_addr;
  logic [ENTRY_W-1:0]     wr_data;
  logic [IDX_W-1:0]       rd_addr;
  logic [ENTRY_W-1:0]     rd_data;
  logic [IDX_W-1:0]       rd_kid0, rd_kid1;
  logic [SYM_W-1:0]       rd_sym;

  logic                   out_free;
  logic                   blocked;
  logic                   at_root;
  logic [IDX_W-1:0]       ev_kid0, ev_kid1;
  logic [IDX_W-1:0]       step_nxt;
  logic [IDX_W-1:0]       new_idx;

  pctd_node_ram #(
    .DEPTH  (MAX_NODES),
    .DATA_W (ENTRY_W)
  ) u_node_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  assign rd_kid1 = rd_data[ENTRY_W-1 -: IDX_W];
  assign rd_kid0 = rd_data[SYM_W +: IDX_W];
  assign rd_sym  = rd_data[SYM_W-1:0];

  assign out_free = !out_valid_q || out_o.ready;
  assign blocked  = pend_valid_q && !out_free;
  assign at_root  = (build_cur_q == '0);
  assign ev_kid0  = at_root ? root_kid0_q : rd_kid0;
  assign ev_kid1  = at_root ? root_kid1_q : rd_kid1;
  assign step_nxt = byte_q[bit_idx_q] ? cur_kid1_q : cur_kid0_q;
  assign new_idx  = node_count_q[IDX_W-1:0];

  assign in_i.ready       = (state_q == ST_IDLE);
  assign out_o.valid      = out_valid_q;
  assign out_o.symbol     = out_sym_q;
  assign out_o.bad_code   = out_bad_q;
  assign out_o.block_done = out_done_q;
  assign out_o.last       = out_last_q;

  always_comb begin
    state_d      = state_q;
    node_count_d = node_count_q;
    build_cur_d  = build_cur_q;
    decode_cur_d = decode_cur_q;
    sym_cnt_d    = sym_cnt_q;
    left_d       = left_q;
    root_kid0_d  = root_kid0_q;
    root_kid1_d  = root_kid1_q;
    pend_valid_d = pend_valid_q;
    elem_d       = elem_q;
    byte_d       = byte_q;
    bit_idx_d    = bit_idx_q;
    cur_kid0_d   = cur_kid0_q;
    cur_kid1_d   = cur_kid1_q;
    nxt_d        = nxt_q;
    pend_sym_d   = pend_sym_q;
    pend_bad_d   = pend_bad_q;
    pend_done_d  = pend_done_q;
    out_valid_d  = out_valid_q && !out_o.ready;
    out_sym_d    = out_sym_q;
    out_bad_d    = out_bad_q;
    out_done_d   = out_done_q;
    out_last_d   = out_last_q;
    wr_en        = 1'b0;
    wr_addr      = build_cur_q;
    wr_data      = '0;
    rd_addr      = nxt_q;

    unique case (state_q)
      ST_IDLE: begin
        rd_addr = (in_i.cmd == CMD_DATA) ? decode_cur_q : build_cur_q;
        if (in_i.valid) begin
          if (in_i.cmd == CMD_START) begin
            node_count_d = CNT_W'(1);
            build_cur_d  = '0;
            decode_cur_d = '0;
            sym_cnt_d    = '0;
            root_kid0_d  = '0;
            root_kid1_d  = '0;
            left_d       = LENGTH_BITS'(in_i.block_length);
          end else if (in_i.cmd == CMD_CODE) begin
            elem_d = in_i.code_element;
            if (in_i.code_element == ELEM_ZERO || in_i.code_element == ELEM_ONE ||
                in_i.code_element == ELEM_END) begin
              state_d = ST_B_EVAL;
            end
          end else if (in_i.cmd == CMD_DATA) begin
            byte_d    = in_i.data_byte;
            bit_idx_d = BYTE_MSB;
            if (left_q != '0) begin
              state_d = ST_D_LOAD;
            end
          end
        end
      end

      ST_B_EVAL: begin
        state_d = ST_IDLE;
        if (elem_q == ELEM_END) begin
          if (!at_root) begin
            wr_en   = 1'b1;
            wr_addr = build_cur_q;
            wr_data = {ev_kid1, ev_kid0, sym_cnt_q[SYM_W-1:0]};
          end
          build_cur_d = '0;
          sym_cnt_d   = sym_cnt_q + SYMCNT_W'(1);
        end else if (((elem_q == ELEM_ONE) ? ev_kid1 : ev_kid0) != '0) begin
          build_cur_d = (elem_q == ELEM_ONE) ? ev_kid1 : ev_kid0;
        end else if (node_count_q != CNT_W'(MAX_NODES)) begin
          if (at_root) begin
            if (elem_q == ELEM_ONE) begin
              root_kid1_d = new_idx;
            end else begin
              root_kid0_d = new_idx;
            end
          end else begin
            wr_en   = 1'b1;
            wr_addr = build_cur_q;
            wr_data = (elem_q == ELEM_ONE) ? {new_idx, ev_kid0, rd_sym}
                                           : {ev_kid1, new_idx, rd_sym};
          end
          nxt_d        = new_idx;
          build_cur_d  = new_idx;
          node_count_d = node_count_q + CNT_W'(1);
          state_d      = ST_B_ZERO;
        end
      end

      ST_B_ZERO: begin
        wr_en   = 1'b1;
        wr_addr = nxt_q;
        wr_data = '0;
        state_d = ST_IDLE;
      end

      ST_D_LOAD: begin
        cur_kid0_d = (decode_cur_q == '0) ? root_kid0_q : rd_kid0;
        cur_kid1_d = (decode_cur_q == '0) ? root_kid1_q : rd_kid1;
        state_d    = ST_D_STEP;
      end

      ST_D_STEP: begin
        if (step_nxt != '0) begin
          rd_addr = step_nxt;
          nxt_d   = step_nxt;
          state_d = ST_D_CHECK;
        end else if (!blocked) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_sym_d   = pend_sym_q;
            out_bad_d   = pend_bad_q;
            out_done_d  = pend_done_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_sym_d   = '0;
          pend_bad_d   = 1'b1;
          pend_done_d  = 1'b0;
          decode_cur_d = '0;
          cur_kid0_d   = root_kid0_q;
          cur_kid1_d   = root_kid1_q;
          bit_idx_d    = bit_idx_q - BITIDX_W'(1);
          state_d      = (bit_idx_q == '0) ? ST_FLUSH : ST_D_STEP;
        end
      end

      ST_D_CHECK: begin
        if (rd_kid0 != '0 || rd_kid1 != '0) begin
          decode_cur_d = nxt_q;
          cur_kid0_d   = rd_kid0;
          cur_kid1_d   = rd_kid1;
          bit_idx_d    = bit_idx_q - BITIDX_W'(1);
          if (bit_idx_q == '0) begin
            state_d = pend_valid_q ? ST_FLUSH : ST_IDLE;
          end else begin
            state_d = ST_D_STEP;
          end
        end else if (!blocked) begin
          if (pend_valid_q) begin
            out_valid_d = 1'b1;
            out_sym_d   = pend_sym_q;
            out_bad_d   = pend_bad_q;
            out_done_d  = pend_done_q;
            out_last_d  = 1'b0;
          end
          pend_valid_d = 1'b1;
          pend_sym_d   = rd_sym;
          pend_bad_d   = 1'b0;
          pend_done_d  = (left_q == LENGTH_BITS'(1));
          left_d       = left_q - LENGTH_BITS'(1);
          decode_cur_d = '0;
          cur_kid0_d   = root_kid0_q;
          cur_kid1_d   = root_kid1_q;
          bit_idx_d    = bit_idx_q - BITIDX_W'(1);
          if (bit_idx_q == '0 || left_q == LENGTH_BITS'(1)) begin
            state_d = ST_FLUSH;
          end else begin
            state_d = ST_D_STEP;
          end
        end
      end

      ST_FLUSH: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_sym_d    = pend_sym_q;
          out_bad_d    = pend_bad_q;
          out_done_d   = pend_done_q;
          out_last_d   = 1'b1;
          pend_valid_d = 1'b0;
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      node_count_q <= CNT_W'(1);
      build_cur_q  <= '0;
      decode_cur_q <= '0;
      sym_cnt_q    <= '0;
      left_q       <= '0;
      root_kid0_q  <= '0;
      root_kid1_q  <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      node_count_q <= node_count_d;
      build_cur_q  <= build_cur_d;
      decode_cur_q <= decode_cur_d;
      sym_cnt_q    <= sym_cnt_d;
      left_q       <= left_d;
      root_kid0_q  <= root_kid0_d;
      root_kid1_q  <= root_kid1_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    elem_q      <= elem_d;
    byte_q      <= byte_d;
    bit_idx_q   <= bit_idx_d;
    cur_kid0_q  <= cur_kid0_d;
    cur_kid1_q  <= cur_kid1_d;
    nxt_q       <= nxt_d;
    pend_sym_q  <= pend_sym_d;
    pend_bad_q  <= pend_bad_d;
    pend_done_q <= pend_done_d;
    out_sym_q   <= out_sym_d;
    out_bad_q   <= out_bad_d;
    out_done_q  <= out_done_d;
    out_last_q  <= out_last_d;
  end

`ifndef SYNTH
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    node_count_q >= CNT_W'(1) && node_count_q <= CNT_W'(MAX_NODES))
    else $error("Node count left its legal range.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    CNT_W'(build_cur_q) < node_count_q && CNT_W'(decode_cur_q) < node_count_q)
    else $error("A tree cursor points past the allocated nodes.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_i.ready |-> !pend_valid_q)
    else $error("A held result was not delivered before taking a new beat.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.bad_code |-> out_o.symbol == '0 && !out_o.block_done)
    else $error("A bad-code result carries a symbol or a block-done mark.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.block_done |-> out_o.last)
    else $error("Block-done result is not the final one of its beat.");
`endif

endmodule

// ===== rtl/pctd_node_ram.sv =====
// Single write port, single registered read port memory for the code tree nodes.
module pctd_node_ram #(
  parameter int DEPTH  = 512,
  parameter int DATA_W = 26
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wr_data_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rd_data_o
);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [DATA_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule
